>>> hdl/lts_pkg.sv
`default_nettype none

package lts_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_BITS  = 24;
  localparam int MAX_OUT     = 16;

  // Smallest usable ratio; anything below it is raised to this value.
  localparam int MIN_RATIO = (1 << FRAC_BITS) / MAX_OUT;

  // Position accumulator: integer part one bit wider than a count, so that
  // the step past the last reachable position cannot wrap.
  localparam int ACC_BITS = COUNT_BITS + FRAC_BITS + 1;

  // Shared signed multiplier operand and product widths.
  localparam int MUL_A_BITS = (SAMPLE_BITS > RATIO_BITS) ? SAMPLE_BITS + 1 : RATIO_BITS + 1;
  localparam int MUL_B_BITS = (COUNT_BITS > FRAC_BITS) ? COUNT_BITS + 1 : FRAC_BITS + 1;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  localparam int RUN_BITS = $clog2(MAX_OUT + 1);
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_RATIO = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IN_COUNT   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_COUNT  = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio;
    logic [COUNT_BITS-1:0] in_count;
    logic [COUNT_BITS-1:0] out_count;
  } cfg_t;

  typedef struct packed {
    logic                   push;
    logic [SAMPLE_BITS-1:0] value;
    logic [COUNT_BITS-1:0]  out_index;
    logic                   status;
    logic                   run_end;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/lts_mul.sv
`default_nettype none

module lts_mul
  import lts_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic signed [MUL_A_BITS-1:0] mul_a,
  input  wire logic signed [MUL_B_BITS-1:0] mul_b,
  output      logic signed [MUL_P_BITS-1:0] mul_p_r
);

  logic signed [MUL_P_BITS-1:0] mul_p_nxt;

  assign mul_p_nxt = MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);

  always_ff @(posedge clk) begin
    mul_p_r <= mul_p_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/lts_seq.sv
`default_nettype none

module lts_seq
  import lts_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   in_take,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_last,
  input  wire logic                   slot_free,
  output      logic                   idle,
  output      res_t                   res
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_LOOP   = 6'b001000,
    ST_ADD    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic        [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic        [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_BITS:0]   diff_r, diff_nxt;
  logic                          last_r, last_nxt;
  logic        [COUNT_BITS-1:0]  k_r, k_nxt;
  logic        [COUNT_BITS-1:0]  oidx_r, oidx_nxt;
  logic        [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic                          rej_r, rej_nxt;
  logic        [RUN_BITS-1:0]    n_r, n_nxt;
  logic        [SAMPLE_BITS-1:0] hold_r, hold_nxt;
  logic        [COUNT_BITS-1:0]  hold_idx_r, hold_idx_nxt;
  logic                          hold_v_r, hold_v_nxt;

  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [MUL_P_BITS-1:0] mul_p_r;

  logic too_long;
  logic more;

  lts_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p_r)
  );

  // The multiplier checks the trace length before the loop and forms the
  // interpolation products inside it.
  always_comb begin
    if (state_r == ST_LOOP) begin
      mul_a = MUL_A_BITS'(diff_r);
      mul_b = MUL_B_BITS'(acc_r[FRAC_BITS-1:0]);
    end else begin
      mul_a = MUL_A_BITS'(cfg.ratio);
      mul_b = MUL_B_BITS'(cfg.out_count);
    end
  end

  assign too_long = (k_r == '0) && !rej_r &&
                    ($unsigned(mul_p_r) > MUL_P_BITS'({cfg.in_count, {FRAC_BITS{1'b0}}}));

  assign more = (n_r < RUN_BITS'(MAX_OUT)) && (oidx_r < cfg.out_count) &&
                (acc_r[ACC_BITS-1:FRAC_BITS] < {1'b0, k_r});

  assign idle = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    diff_nxt     = diff_r;
    last_nxt     = last_r;
    k_nxt        = k_r;
    oidx_nxt     = oidx_r;
    acc_nxt      = acc_r;
    rej_nxt      = rej_r;
    n_nxt        = n_r;
    hold_nxt     = hold_r;
    hold_idx_nxt = hold_idx_r;
    hold_v_nxt   = hold_v_r;
    res          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cur_nxt    = in_sample;
          last_nxt   = in_last;
          diff_nxt   = $signed({in_sample[SAMPLE_BITS-1], in_sample}) -
                       $signed({prev_r[SAMPLE_BITS-1], prev_r});
          n_nxt      = '0;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (too_long) begin
          if (slot_free) begin
            res.push    = 1'b1;
            res.status  = STATUS_RANGE;
            res.run_end = 1'b1;
            rej_nxt     = 1'b1;
            state_nxt   = ST_DONE;
          end
        end else if (!rej_r && (k_r != '0) && (k_r < cfg.in_count)) begin
          state_nxt = ST_LOOP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LOOP: begin
        // A held result goes out once we know whether another follows it.
        if (!hold_v_r || slot_free) begin
          if (hold_v_r) begin
            res.push      = 1'b1;
            res.value     = hold_r;
            res.out_index = hold_idx_r;
            res.status    = STATUS_OK;
            res.run_end   = !more;
            hold_v_nxt    = 1'b0;
          end
          state_nxt = more ? ST_ADD : ST_DONE;
        end
      end
      ST_ADD: begin
        hold_nxt     = prev_r + mul_p_r[FRAC_BITS +: SAMPLE_BITS];
        hold_idx_nxt = oidx_r;
        hold_v_nxt   = 1'b1;
        oidx_nxt     = oidx_r + 1'b1;
        acc_nxt      = acc_r + ACC_BITS'(cfg.ratio);
        n_nxt        = n_r + 1'b1;
        state_nxt    = ST_LOOP;
      end
      ST_DONE: begin
        prev_nxt = cur_r;
        if (k_r != {COUNT_BITS{1'b1}}) begin
          k_nxt = k_r + 1'b1;
        end
        if (last_r) begin
          prev_nxt = '0;
          k_nxt    = '0;
          oidx_nxt = '0;
          acc_nxt  = '0;
          rej_nxt  = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      prev_r   <= '0;
      k_r      <= '0;
      oidx_r   <= '0;
      acc_r    <= '0;
      rej_r    <= 1'b0;
      hold_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      prev_r   <= prev_nxt;
      k_r      <= k_nxt;
      oidx_r   <= oidx_nxt;
      acc_r    <= acc_nxt;
      rej_r    <= rej_nxt;
      hold_v_r <= hold_v_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    diff_r     <= diff_nxt;
    last_r     <= last_nxt;
    hold_r     <= hold_nxt;
    hold_idx_r <= hold_idx_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/linear_trace_resampler_top.sv
`default_nettype none

// Linear interpolation resampler for one trace at a time. Input beats carry
// a signed sample and a last flag; output j sits at position j * step_ratio
// (unsigned Q8.16, in input-sample units) and is produced when the input
// sample just past that position arrives, as prev + frac * (cur - prev) with
// the product floored. Each result beat carries the value, its index in the
// trace, a status bit and run_end, which marks the final result caused by
// one input beat. If out_count * step_ratio exceeds in_count, the first
// sample of the trace gives a single result with status 1 and the rest of
// the trace, up to its last sample, gives nothing. Ratios below 1/16 are
// treated as 1/16, so one input yields at most sixteen results. An input
// beat that never enters the interpolation loop (the first beat of a
// trace, any beat of a refused trace, beats at or past in_count, and the
// beat that raises the range error) passes through the multiply, decide
// and done states; one that enters the loop and produces n results, n
// possibly zero, also passes through the loop state and, once per result,
// the add state. Either path lasts longer while the output side stalls. A
// single shared multiplier, used once for the length check and once per
// result, serves a small sequencer; in_stall stays high until the beat is
// fully processed, so no new beat is taken before then.
// Configuration registers (0 step_ratio, 1 in_count, 2 out_count) should be
// written only while the block is idle; writes to other indices are
// ignored.

module linear_trace_resampler_top
  import lts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [SAMPLE_BITS-1:0]    in_sample,
  input  wire logic                      in_last,

  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic [SAMPLE_BITS-1:0]    out_value,
  output      logic [COUNT_BITS-1:0]     out_index,
  output      logic                      out_status,
  output      logic                      out_run_end,

  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [RATIO_BITS-1:0]     cfg_data
);

  logic [RATIO_BITS-1:0] ratio_r;
  logic [COUNT_BITS-1:0] in_count_r;
  logic [COUNT_BITS-1:0] out_count_r;

  cfg_t cfg;
  res_t res;
  logic idle;
  logic in_take;
  logic slot_free;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_value_r;
  logic [COUNT_BITS-1:0]  out_index_r;
  logic                   out_status_r;
  logic                   out_run_end_r;

  // The register file is always able to take a write beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r     <= RATIO_BITS'(1 << FRAC_BITS);
      in_count_r  <= {COUNT_BITS{1'b1}};
      out_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_RATIO: ratio_r     <= cfg_data;
        CFG_IN_COUNT:   in_count_r  <= cfg_data[COUNT_BITS-1:0];
        CFG_OUT_COUNT:  out_count_r <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the ratio here so the sequencer never sees a step below 1/16.
  always_comb begin
    cfg.ratio     = (ratio_r < RATIO_BITS'(MIN_RATIO)) ? RATIO_BITS'(MIN_RATIO) : ratio_r;
    cfg.in_count  = in_count_r;
    cfg.out_count = out_count_r;
  end

  assign in_stall = !idle;
  assign in_take  = in_valid && !in_stall;

  // A single output register: a new result may enter when it is empty or
  // when its current beat is being taken this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  lts_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_take   (in_take),
    .in_sample (in_sample),
    .in_last   (in_last),
    .slot_free (slot_free),
    .idle      (idle),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      out_value_r   <= res.value;
      out_index_r   <= res.out_index;
      out_status_r  <= res.status;
      out_run_end_r <= res.run_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_index   = out_index_r;
  assign out_status  = out_status_r;
  assign out_run_end = out_run_end_r;

`ifndef SYNTHESIS
  // An accepted input beat always keeps the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while block stayed idle");

  // The range error is always a lone result, so it closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_RANGE) |-> out_run_end)
    else $error("range error without run_end");

  // The range error carries zero value and index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_RANGE) |-> (out_value == '0) && (out_index == '0))
    else $error("range error with non-zero payload");

  // The sequencer never pushes into an occupied, stalled output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    res.push |-> slot_free)
    else $error("result pushed over a pending beat");
`endif

endmodule

`default_nettype wire
